/* rtl/exti_pkg.sv */
// Package for the external interrupt edge controller.
// Holds the line and port counts, access codes and the result payload type.
// No dependencies.
`timescale 1ns / 1ps

package exti_pkg;

  localparam int LINE_COUNT = 16;
  localparam int PORT_COUNT = 11;

  // Register file always spans 16 lines; lines at or above LINE_COUNT read as zero.
  localparam int REG_W = 16;
  localparam int PORT_W = 4;
  localparam int IRQ_W = 7;
  localparam logic [REG_W-1:0] LINE_MASK = REG_W'((32'd1 << LINE_COUNT) - 32'd1);

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  localparam logic [2:0] REG_MASK = 3'd0;
  localparam logic [2:0] REG_RISE = 3'd1;
  localparam logic [2:0] REG_FALL = 3'd2;
  localparam logic [2:0] REG_PEND = 3'd3;

  typedef struct packed {
    logic              sample;
    logic [PORT_W-1:0] port;
  } lane_ctl_t;

  typedef struct packed {
    logic [REG_W-1:0] read_data;
    logic [IRQ_W-1:0] irq_lines;
    logic             bad_access;
  } result_t;

endpackage

/* rtl/exti_if.sv */
// Request and result channel interfaces of the external interrupt controller.
// Depends on exti_pkg for field widths.
`timescale 1ns / 1ps

interface exti_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic [2:0]                reg_select;
  logic [exti_pkg::REG_W-1:0]  write_data;
  logic [exti_pkg::PORT_W-1:0] port_code;
  logic [exti_pkg::REG_W-1:0]  pin_levels;

  modport source (output valid, mode, reg_select, write_data, port_code, pin_levels,
                  input ready);
  modport sink (input valid, mode, reg_select, write_data, port_code, pin_levels,
                output ready);
endinterface

interface exti_out_if;
  logic                       valid;
  logic                       ready;
  logic [exti_pkg::REG_W-1:0] read_data;
  logic [exti_pkg::IRQ_W-1:0] irq_lines;
  logic                       bad_access;

  modport source (output valid, read_data, irq_lines, bad_access, input ready);
  modport sink (input valid, read_data, irq_lines, bad_access, output ready);
endinterface

/* rtl/exti_lane.sv */
// One pin line: stored level and edge detection against the sampled port.
// Depends on exti_pkg.
`timescale 1ns / 1ps

module exti_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  exti_pkg::lane_ctl_t         ctl,
  input  logic [exti_pkg::PORT_W-1:0] port_sel,
  input  logic                        pin,
  input  logic                        rise_en,
  input  logic                        fall_en,
  input  logic                        mask_en,
  output logic                        pend_set
);
  import exti_pkg::*;

  logic last_r;
  logic last_nxt;
  logic match;
  logic edge_hit;

  assign match    = ctl.sample && (port_sel == ctl.port);
  assign edge_hit = (!last_r && pin && rise_en) || (last_r && !pin && fall_en);
  assign pend_set = match && edge_hit && mask_en;
  assign last_nxt = match ? pin : last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 1'b0;
    end else begin
      last_r <= last_nxt;
    end
  end

endmodule

/* rtl/exti_merge.sv */
// Builds the pending register's next value from the lanes' requests or a clear
// and folds pending, unmasked lines into the grouped interrupt outputs.
// Depends on exti_pkg.
`timescale 1ns / 1ps

module exti_merge (
  input  logic [exti_pkg::REG_W-1:0] pend_r,
  input  logic [exti_pkg::REG_W-1:0] lane_set,
  input  logic                       clr_en,
  input  logic [exti_pkg::REG_W-1:0] clr_bits,
  input  logic [exti_pkg::REG_W-1:0] mask_nxt,
  output logic [exti_pkg::REG_W-1:0] pend_nxt,
  output logic [exti_pkg::IRQ_W-1:0] irq_lines
);
  import exti_pkg::*;

  logic [REG_W-1:0] active;

  always_comb begin
    if (clr_en) begin
      pend_nxt = pend_r & ~clr_bits & LINE_MASK;
    end else begin
      pend_nxt = (pend_r | lane_set) & LINE_MASK;
    end
  end

  assign active    = pend_nxt & mask_nxt & LINE_MASK;
  assign irq_lines = {|active[15:10], |active[9:5], active[4:0]};

endmodule

/* rtl/external_interrupt_edge_controller.sv */
// Channel    Dir  Handshake      Payload
// in_ch      in   valid/ready    mode, reg_select, write_data, port_code, pin_levels
// out_ch     out  valid/ready    read_data, irq_lines, bad_access
//
// Each request updates the state at the edge it is accepted, and its result is
// registered; one request per cycle is sustained while out_ch takes results.
// The result register plus a one-entry skid stage decouple the two sides, so
// in_ch.ready drops only when both hold a result that out_ch has not taken.
// Synchronous active-low reset clears lane levels and all but the result data.
// Depends on exti_pkg, exti_if, exti_lane and exti_merge.
`timescale 1ns / 1ps

module external_interrupt_edge_controller (
  input logic         clk,
  input logic         rst_n,
  exti_in_if.sink     in_ch,
  exti_out_if.source  out_ch
);
  import exti_pkg::*;

  logic [REG_W-1:0]  mask_r, mask_nxt;
  logic [REG_W-1:0]  rise_r, rise_nxt;
  logic [REG_W-1:0]  fall_r, fall_nxt;
  logic [REG_W-1:0]  pend_r, pend_nxt;
  logic [PORT_W-1:0] port_r [REG_W];

  logic              in_fire;
  logic              out_fire;
  mode_t             mode;
  logic              is_tick;
  logic              is_write;
  logic              port_ok;
  lane_ctl_t         ctl;
  logic [REG_W-1:0]  lane_set;
  logic              clr_en;
  logic [IRQ_W-1:0]  irq;
  logic [REG_W-1:0]  rd;
  result_t           res;

  result_t           out_r;
  logic              out_v_r;
  result_t           skid_r;
  logic              skid_v_r;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_v_r && out_ch.ready;
  assign mode     = mode_t'(in_ch.mode);
  assign is_tick  = in_fire && (mode == MODE_TICK);
  assign is_write = in_fire && (mode == MODE_WRITE);
  assign port_ok  = {1'b0, in_ch.port_code} < 5'(PORT_COUNT);

  assign ctl.sample = is_tick && port_ok;
  assign ctl.port   = in_ch.port_code;

  for (genvar n = 0; n < REG_W; n++) begin : g_lane
    if (n < LINE_COUNT) begin : g_on
      exti_lane u_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .port_sel (port_r[n]),
        .pin      (in_ch.pin_levels[n]),
        .rise_en  (rise_r[n]),
        .fall_en  (fall_r[n]),
        .mask_en  (mask_r[n]),
        .pend_set (lane_set[n])
      );
    end else begin : g_off
      assign lane_set[n] = 1'b0;
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    rise_nxt = rise_r;
    fall_nxt = fall_r;
    if (is_write) begin
      unique case (in_ch.reg_select)
        REG_MASK: mask_nxt = in_ch.write_data & LINE_MASK;
        REG_RISE: rise_nxt = in_ch.write_data & LINE_MASK;
        REG_FALL: fall_nxt = in_ch.write_data & LINE_MASK;
        default:  ;
      endcase
    end
  end

  assign clr_en = is_write && (in_ch.reg_select == REG_PEND);

  exti_merge u_merge (
    .pend_r    (pend_r),
    .lane_set  (lane_set),
    .clr_en    (clr_en),
    .clr_bits  (in_ch.write_data),
    .mask_nxt  (mask_nxt),
    .pend_nxt  (pend_nxt),
    .irq_lines (irq)
  );

  always_comb begin
    rd = '0;
    if (mode == MODE_READ) begin
      unique case (in_ch.reg_select)
        REG_MASK: rd = mask_r;
        REG_RISE: rd = rise_r;
        REG_FALL: rd = fall_r;
        REG_PEND: rd = pend_r;
        default: begin
          for (int k = 0; k < 4; k++) begin
            rd[PORT_W*k +: PORT_W] = port_r[{in_ch.reg_select[1:0], 2'(k)}];
          end
        end
      endcase
    end
  end

  assign res.read_data  = rd;
  assign res.irq_lines  = irq;
  assign res.bad_access = (mode == MODE_TICK) && !port_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      rise_r <= '0;
      fall_r <= '0;
      pend_r <= '0;
      for (int n = 0; n < REG_W; n++) begin
        port_r[n] <= '0;
      end
    end else begin
      mask_r <= mask_nxt;
      rise_r <= rise_nxt;
      fall_r <= fall_nxt;
      pend_r <= pend_nxt;
      // Port select words are stored whole, codes beyond the last port included.
      if (is_write && in_ch.reg_select[2]) begin
        for (int k = 0; k < 4; k++) begin
          port_r[{in_ch.reg_select[1:0], 2'(k)}] <= in_ch.write_data[PORT_W*k +: PORT_W];
        end
      end
    end
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (out_fire) begin
        if (skid_v_r) begin
          out_r    <= skid_r;
          skid_v_r <= 1'b0;
        end else if (in_fire) begin
          out_r <= res;
        end else begin
          out_v_r <= 1'b0;
        end
      end else if (in_fire) begin
        if (!out_v_r) begin
          out_r   <= res;
          out_v_r <= 1'b1;
        end else begin
          skid_r   <= res;
          skid_v_r <= 1'b1;
        end
      end
    end
  end

  assign in_ch.ready       = !skid_v_r;
  assign out_ch.valid      = out_v_r;
  assign out_ch.read_data  = out_r.read_data;
  assign out_ch.irq_lines  = out_r.irq_lines;
  assign out_ch.bad_access = out_r.bad_access;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held while result register is empty");

  a_bad_tick_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (is_tick && !port_ok) |=> (pend_r == $past(pend_r)))
    else $error("pending changed on a tick with an invalid port");

  a_tick_respects_mask: assert property (@(posedge clk) disable iff (!rst_n)
    is_tick |=> ((pend_r & ~$past(pend_r) & ~$past(mask_r)) == '0))
    else $error("masked line became pending on a tick");

  a_no_phantom_lines: assert property (@(posedge clk) disable iff (!rst_n)
    ((pend_r | mask_r | rise_r | fall_r) & ~LINE_MASK) == '0)
    else $error("state bit set for a nonexistent line");
`endif

endmodule
